### rtl/gpsp_pkg.sv
// Package for the game pad serial port: request and response types,
// register offsets, access codes and pad protocol constants.
// No dependencies.
`default_nettype none

package gpsp_pkg;

   // receive fifo geometry
   localparam int RX_DEPTH = 8;
   localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int RX_SW = RX_CW + 1;

   // access codes
   localparam logic [2:0] FUNC_RD_BYTE = 3'd0;
   localparam logic [2:0] FUNC_RD_HALF = 3'd1;
   localparam logic [2:0] FUNC_WR_BYTE = 3'd2;
   localparam logic [2:0] FUNC_WR_HALF = 3'd3;
   localparam logic [2:0] FUNC_TICK    = 3'd4;

   // register offsets
   localparam logic [4:0] OFF_FIFO = 5'd0;
   localparam logic [4:0] OFF_STAT = 5'd4;
   localparam logic [4:0] OFF_MODE = 5'd8;
   localparam logic [4:0] OFF_CTRL = 5'd10;
   localparam logic [4:0] OFF_BAUD = 5'd14;

   // pad protocol phases
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_ID      = 2'd1;
   localparam logic [1:0] PHASE_BUTTONS = 2'd2;

   // protocol and register constants
   localparam logic [15:0] CTRL_PAD_MASK   = 16'h2002;
   localparam logic [15:0] CTRL_PAD_SEL    = 16'h0002;
   localparam logic [15:0] CTRL_READ_MASK  = 16'h3F03;
   localparam logic [7:0]  TX_START        = 8'h01;
   localparam logic [7:0]  ID_LO           = 8'h41;
   localparam logic [7:0]  ID_HI           = 8'h5A;
   localparam logic [7:0]  CMD_READ        = 8'h42;
   localparam logic [7:0]  EMPTY_BYTE      = 8'hFF;
   localparam logic [15:0] BAUD_VALUE      = 16'h0088;
   localparam logic [15:0] ACK_DELAY_RESET = 16'd1088;

   // control word bits
   localparam int CTRL_ACK_IRQ_BIT = 4;
   localparam int CTRL_RESET_BIT   = 6;
   localparam int CTRL_RX_IRQ_BIT  = 12;

   typedef struct packed {
      logic [2:0]  func;
      logic [4:0]  reg_offset;
      logic [15:0] wdata;
      logic [15:0] pad_buttons;
   } req_type;

   typedef struct packed {
      logic [15:0] rdata;
      logic        irq_pulse;
      logic        irq_pending;
      logic        bad_access;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctl_type;

endpackage

`default_nettype wire

### rtl/game_pad_serial_port_unit.sv
// Game pad serial port: request register, core and response register.
// Depends on gpsp_pkg and gpsp_core.
//
// Usage:
//   req channel carries one bus access or tick (func, reg_offset, wdata,
//   pad_buttons); rsp channel returns exactly one response per request
//   (rdata, irq_pulse, irq_pending, bad_access), in request order.
//   csr channel writes the acknowledge delay in ticks; it is always ready
//   and should be written only while no request is in flight.
// Path: an accepted request waits in the request register, then its result
//   from the core is registered in the response register, raising rsp_valid.
// Throughput: one request per cycle; the request register, the single
//   pass through the core and the response register overlap, so req_ready
//   stays high as long as the response side keeps taking results.
// Stall: when rsp_ready is low the response register holds its result,
//   the request register keeps one more request, then req_ready drops.
// Reset: synchronous; both registers empty, port state cleared, receive
//   fifo empty and the acknowledge delay back at 1088 ticks.
`default_nettype none

module game_pad_serial_port_unit
   import gpsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type core_result;
   logic    advance;

   // request moves into the response register when that slot frees
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gpsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .item      (in_data_ff),
      .csr_we    (csr_valid),
      .csr_wdata (csr_wdata),
      .result    (core_result)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

endmodule

`default_nettype wire

### rtl/gpsp_fifo.sv
// Receive fifo of the game pad serial port: ring buffer with head and count.
// Depends on gpsp_pkg.
`default_nettype none

module gpsp_fifo
   import gpsp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fifo_ctl_type     ctl,
   input  wire logic [7:0]       push_data,
   output logic      [7:0]       head_data,
   output logic                  not_empty
);

   logic [7:0]       store_ff [RX_DEPTH];
   logic [RX_AW-1:0] head_ff, head_in;
   logic [RX_CW-1:0] count_ff, count_in;
   logic [RX_SW-1:0] pos_wide;
   logic [RX_AW-1:0] push_pos;
   logic             full;
   logic             do_push;

   assign full      = (count_ff == RX_CW'(RX_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = store_ff[head_ff];
   assign do_push   = ctl.push && !full;

   // tail position, wrapped once
   always_comb begin
      pos_wide = RX_SW'(head_ff) + RX_SW'(count_ff);
      if (pos_wide >= RX_SW'(RX_DEPTH)) begin
         pos_wide = pos_wide - RX_SW'(RX_DEPTH);
      end
      push_pos = pos_wide[RX_AW-1:0];
   end

   // pointer update
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      priority if (ctl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (ctl.pop && not_empty) begin
         head_in  = (head_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (do_push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // byte storage
   always_ff @(posedge clock) begin
      if (do_push && !ctl.clear) begin
         store_ff[push_pos] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/gpsp_core.sv
// Register window and pad protocol machine of the game pad serial port.
// Depends on gpsp_pkg and gpsp_fifo.
`default_nettype none

module gpsp_core
   import gpsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step_en,
   input  wire req_type     item,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   output rsp_type          result
);

   logic [15:0] ack_delay_ff;
   logic [15:0] ctrl_word_ff, ctrl_word_in;
   logic        tx_ready_ff, tx_ready_in;
   logic        ack_flag_ff, ack_flag_in;
   logic        irq_flag_ff, irq_flag_in;
   logic [1:0]  pad_phase_ff, pad_phase_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic        reply_pending_ff, reply_pending_in;
   logic [7:0]  reply_byte_ff, reply_byte_in;
   logic [15:0] reply_countdown_ff, reply_countdown_in;

   fifo_ctl_type fifo_ctl, fifo_req;
   logic [7:0]   push_data;
   logic [7:0]   head_data;
   logic         not_empty;
   logic [1:0]   bytes_dec;
   logic [7:0]   tx_byte;
   logic         arm;
   logic [7:0]   arm_byte;

   gpsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .push_data (push_data),
      .head_data (head_data),
      .not_empty (not_empty)
   );

   assign bytes_dec = bytes_left_ff - 2'd1;
   assign tx_byte   = item.wdata[7:0];

   // decode one request against the current state
   always_comb begin
      ctrl_word_in       = ctrl_word_ff;
      tx_ready_in        = tx_ready_ff;
      ack_flag_in        = ack_flag_ff;
      irq_flag_in        = irq_flag_ff;
      pad_phase_in       = pad_phase_ff;
      bytes_left_in      = bytes_left_ff;
      reply_pending_in   = reply_pending_ff;
      reply_byte_in      = reply_byte_ff;
      reply_countdown_in = reply_countdown_ff;
      fifo_req           = '0;
      push_data          = EMPTY_BYTE;
      arm                = 1'b0;
      arm_byte           = EMPTY_BYTE;
      result             = '0;

      unique case (item.func)
         FUNC_TICK: begin
            if (reply_pending_ff) begin
               if (reply_countdown_ff > 16'd1) begin
                  reply_countdown_in = reply_countdown_ff - 16'd1;
               end else begin
                  reply_countdown_in = '0;
                  reply_pending_in   = 1'b0;
                  fifo_req.push      = 1'b1;
                  push_data          = reply_byte_ff;
                  tx_ready_in        = 1'b1;
                  ack_flag_in        = 1'b1;
                  if (ctrl_word_ff[CTRL_RX_IRQ_BIT]) begin
                     irq_flag_in      = 1'b1;
                     result.irq_pulse = 1'b1;
                  end
               end
            end
         end
         FUNC_RD_BYTE: begin
            if (!item.reg_offset[4]) begin
               if (item.reg_offset == OFF_FIFO) begin
                  fifo_req.pop = not_empty;
                  result.rdata = not_empty ? {8'h00, head_data} : {8'h00, EMPTY_BYTE};
               end else begin
                  result.bad_access = 1'b1;
               end
            end
         end
         FUNC_RD_HALF: begin
            if (!item.reg_offset[4]) begin
               if (item.reg_offset == OFF_STAT) begin
                  result.rdata = {6'd0, irq_flag_ff, 1'b0, ack_flag_ff, 4'd0,
                                  tx_ready_ff, not_empty, tx_ready_ff};
                  ack_flag_in  = 1'b0;
               end else if (item.reg_offset == OFF_CTRL) begin
                  result.rdata = ctrl_word_ff & CTRL_READ_MASK;
               end else if (item.reg_offset == OFF_BAUD) begin
                  result.rdata = BAUD_VALUE;
               end else begin
                  result.bad_access = 1'b1;
               end
            end
         end
         FUNC_WR_BYTE: begin
            if (!item.reg_offset[4]) begin
               if (item.reg_offset == OFF_FIFO) begin
                  // transmit byte advances the pad protocol
                  tx_ready_in = 1'b0;
                  if (pad_phase_ff == PHASE_ID) begin
                     arm      = 1'b1;
                     arm_byte = (bytes_left_ff == 2'd2) ? ID_LO : ID_HI;
                     bytes_left_in = bytes_dec;
                     if (bytes_dec == 2'd0) begin
                        pad_phase_in  = PHASE_BUTTONS;
                        bytes_left_in = 2'd2;
                     end else if (tx_byte != CMD_READ) begin
                        pad_phase_in = PHASE_IDLE;
                     end
                  end else if (pad_phase_ff == PHASE_BUTTONS) begin
                     arm      = 1'b1;
                     arm_byte = (bytes_left_ff == 2'd2) ? item.pad_buttons[7:0]
                                                        : item.pad_buttons[15:8];
                     bytes_left_in = bytes_dec;
                     if (bytes_dec == 2'd0) begin
                        pad_phase_in = PHASE_IDLE;
                     end
                  end else begin
                     if (tx_byte == TX_START &&
                         (ctrl_word_ff & CTRL_PAD_MASK) == CTRL_PAD_SEL) begin
                        arm           = 1'b1;
                        arm_byte      = EMPTY_BYTE;
                        pad_phase_in  = PHASE_ID;
                        bytes_left_in = 2'd2;
                     end else begin
                        pad_phase_in  = PHASE_IDLE;
                        fifo_req.push = 1'b1;
                        push_data     = EMPTY_BYTE;
                        tx_ready_in   = 1'b1;
                     end
                  end
               end else begin
                  result.bad_access = 1'b1;
               end
            end
         end
         FUNC_WR_HALF: begin
            if (!item.reg_offset[4]) begin
               if (item.reg_offset == OFF_CTRL) begin
                  ctrl_word_in = item.wdata;
                  if (item.wdata[CTRL_ACK_IRQ_BIT]) begin
                     irq_flag_in = 1'b0;
                  end
                  if (item.wdata[CTRL_RESET_BIT]) begin
                     tx_ready_in    = 1'b1;
                     irq_flag_in    = 1'b0;
                     pad_phase_in   = PHASE_IDLE;
                     fifo_req.clear = 1'b1;
                  end
                  if (item.wdata == 16'd0) begin
                     pad_phase_in   = PHASE_IDLE;
                     fifo_req.clear = 1'b1;
                  end
               end else if (item.reg_offset != OFF_MODE && item.reg_offset != OFF_BAUD) begin
                  result.bad_access = 1'b1;
               end
            end
         end
         default: begin
            result.bad_access = 1'b1;
         end
      endcase

      // delayed acknowledge arming
      if (arm) begin
         reply_byte_in      = arm_byte;
         reply_pending_in   = 1'b1;
         reply_countdown_in = ack_delay_ff;
      end

      result.irq_pending = irq_flag_in;
   end

   // fifo actions only for the request being retired
   assign fifo_ctl.push  = step_en & fifo_req.push;
   assign fifo_ctl.pop   = step_en & fifo_req.pop;
   assign fifo_ctl.clear = step_en & fifo_req.clear;

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_word_ff       <= '0;
         tx_ready_ff        <= 1'b0;
         ack_flag_ff        <= 1'b0;
         irq_flag_ff        <= 1'b0;
         pad_phase_ff       <= PHASE_IDLE;
         bytes_left_ff      <= '0;
         reply_pending_ff   <= 1'b0;
         reply_byte_ff      <= '0;
         reply_countdown_ff <= '0;
      end else if (step_en) begin
         ctrl_word_ff       <= ctrl_word_in;
         tx_ready_ff        <= tx_ready_in;
         ack_flag_ff        <= ack_flag_in;
         irq_flag_ff        <= irq_flag_in;
         pad_phase_ff       <= pad_phase_in;
         bytes_left_ff      <= bytes_left_in;
         reply_pending_ff   <= reply_pending_in;
         reply_byte_ff      <= reply_byte_in;
         reply_countdown_ff <= reply_countdown_in;
      end
   end

   // acknowledge delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_delay_ff <= ACK_DELAY_RESET;
      end else if (csr_we) begin
         ack_delay_ff <= csr_wdata;
      end
   end

endmodule

`default_nettype wire

### tb/gpsp_port_checker.sv
// Response checker for the game pad serial port: keeps its own copy of the
// port registers, pad protocol and receive fifo, and compares every response.
// Depends on gpsp_pkg.

module gpsp_port_checker
   import gpsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_wdata,
   output int               mismatches,
   output int               waiting,
   output int               irq_pulses
);

   // mirrored port state
   logic [15:0] ack_delay_q;
   logic [15:0] ctrl_q;
   logic [15:0] reply_wait;
   logic        tx_rdy;
   logic        ack_bit;
   logic        irq_bit;
   logic        reply_armed;
   logic [7:0]  reply_val;
   logic [1:0]  phase;
   logic [1:0]  left_cnt;
   logic [7:0]  rx_mem [RX_DEPTH];
   int          rx_fill;
   int          rx_rd;

   // responses owed, oldest first
   rsp_type     rsp_due [$];

   // receive fifo push, new byte dropped when full
   task automatic rx_push(input logic [7:0] b);
      if (rx_fill < RX_DEPTH) begin
         rx_mem[(rx_rd + rx_fill) % RX_DEPTH] = b;
         rx_fill++;
      end
   endtask

   // load the reply byte and restart the acknowledge countdown
   task automatic arm_ack(input logic [7:0] b);
      reply_val = b;
      reply_armed = 1'b1;
      reply_wait = ack_delay_q;
   endtask

   task automatic flag_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $time, field, want, got);
      mismatches++;
   endtask

   // expected response of one request, updating the mirrored state
   task automatic predict_access(input req_type r, output rsp_type e);
      logic [7:0] d;
      d = r.wdata[7:0];
      e = '0;
      case (r.func)
         FUNC_TICK: begin
            if (reply_armed) begin
               if (reply_wait > 16'd1) begin
                  reply_wait = reply_wait - 16'd1;
               end else begin
                  reply_wait = '0;
                  reply_armed = 1'b0;
                  rx_push(reply_val);
                  tx_rdy = 1'b1;
                  ack_bit = 1'b1;
                  if (ctrl_q[CTRL_RX_IRQ_BIT]) begin
                     irq_bit = 1'b1;
                     e.irq_pulse = 1'b1;
                     irq_pulses++;
                  end
               end
            end
         end
         FUNC_RD_BYTE: begin
            if (!r.reg_offset[4]) begin
               if (r.reg_offset != OFF_FIFO) begin
                  e.bad_access = 1'b1;
               end else if (rx_fill == 0) begin
                  e.rdata = {8'h00, EMPTY_BYTE};
               end else begin
                  e.rdata = {8'h00, rx_mem[rx_rd]};
                  rx_rd = (rx_rd + 1) % RX_DEPTH;
                  rx_fill--;
               end
            end
         end
         FUNC_RD_HALF: begin
            if (!r.reg_offset[4]) begin
               if (r.reg_offset == OFF_STAT) begin
                  e.rdata[0] = tx_rdy;
                  e.rdata[1] = (rx_fill != 0);
                  e.rdata[2] = tx_rdy;
                  e.rdata[7] = ack_bit;
                  e.rdata[9] = irq_bit;
                  ack_bit = 1'b0;
               end else if (r.reg_offset == OFF_CTRL) begin
                  e.rdata = ctrl_q & CTRL_READ_MASK;
               end else if (r.reg_offset == OFF_BAUD) begin
                  e.rdata = BAUD_VALUE;
               end else begin
                  e.bad_access = 1'b1;
               end
            end
         end
         FUNC_WR_BYTE: begin
            if (!r.reg_offset[4]) begin
               if (r.reg_offset != OFF_FIFO) begin
                  e.bad_access = 1'b1;
               end else begin
                  // transmit byte drives the pad protocol
                  tx_rdy = 1'b0;
                  case (phase)
                     PHASE_ID: begin
                        arm_ack(left_cnt == 2'd2 ? ID_LO : ID_HI);
                        left_cnt = left_cnt - 2'd1;
                        if (left_cnt == 2'd0) begin
                           phase = PHASE_BUTTONS;
                           left_cnt = 2'd2;
                        end else if (d != CMD_READ) begin
                           phase = PHASE_IDLE;
                        end
                     end
                     PHASE_BUTTONS: begin
                        arm_ack(left_cnt == 2'd2 ? r.pad_buttons[7:0] : r.pad_buttons[15:8]);
                        left_cnt = left_cnt - 2'd1;
                        if (left_cnt == 2'd0) phase = PHASE_IDLE;
                     end
                     default: begin
                        if (d == TX_START && (ctrl_q & CTRL_PAD_MASK) == CTRL_PAD_SEL) begin
                           arm_ack(EMPTY_BYTE);
                           phase = PHASE_ID;
                           left_cnt = 2'd2;
                        end else begin
                           phase = PHASE_IDLE;
                           rx_push(EMPTY_BYTE);
                           tx_rdy = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         FUNC_WR_HALF: begin
            if (!r.reg_offset[4]) begin
               if (r.reg_offset == OFF_CTRL) begin
                  ctrl_q = r.wdata;
                  if (r.wdata[CTRL_ACK_IRQ_BIT]) irq_bit = 1'b0;
                  if (r.wdata[CTRL_RESET_BIT]) begin
                     tx_rdy = 1'b1;
                     irq_bit = 1'b0;
                     phase = PHASE_IDLE;
                     rx_fill = 0;
                     rx_rd = 0;
                  end
                  // zero write times the port out
                  if (r.wdata == '0) begin
                     phase = PHASE_IDLE;
                     rx_fill = 0;
                     rx_rd = 0;
                  end
               end else if (r.reg_offset != OFF_MODE && r.reg_offset != OFF_BAUD) begin
                  e.bad_access = 1'b1;
               end
            end
         end
         default: e.bad_access = 1'b1;
      endcase
      e.irq_pending = irq_bit;
   endtask

   // register writes, then responses, then new requests at each edge
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         ack_delay_q = ACK_DELAY_RESET;
         ctrl_q = '0;
         reply_wait = '0;
         tx_rdy = 1'b0;
         ack_bit = 1'b0;
         irq_bit = 1'b0;
         reply_armed = 1'b0;
         reply_val = '0;
         phase = PHASE_IDLE;
         left_cnt = '0;
         rx_fill = 0;
         rx_rd = 0;
         rsp_due.delete();
         mismatches = 0;
         irq_pulses = 0;
      end else begin
         if (csr_valid && csr_ready) ack_delay_q = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (rsp_due.size() == 0) begin
               $display("%0t response with none due: expected nothing, got %h", $time, got);
               mismatches++;
            end else begin
               want = rsp_due.pop_front();
               if (got.rdata !== want.rdata) flag_field("rdata", want.rdata, got.rdata);
               if (got.irq_pulse !== want.irq_pulse)
                  flag_field("irq_pulse", 16'(want.irq_pulse), 16'(got.irq_pulse));
               if (got.irq_pending !== want.irq_pending)
                  flag_field("irq_pending", 16'(want.irq_pending), 16'(got.irq_pending));
               if (got.bad_access !== want.bad_access)
                  flag_field("bad_access", 16'(want.bad_access), 16'(got.bad_access));
            end
         end
         if (req_valid && req_ready) begin
            predict_access(req_data, want);
            rsp_due.push_back(want);
         end
      end
      waiting <= rsp_due.size();
   end

endmodule

### tb/game_pad_serial_port_unit_tb.sv
// Testbench top for the game pad serial port: clock, reset, request and
// register stimulus, response back-pressure and the final verdict.
// Depends on gpsp_pkg, game_pad_serial_port_unit and gpsp_port_checker.

module game_pad_serial_port_unit_tb
   import gpsp_pkg::*;
();

   localparam logic [15:0] DELAYS [6] = '{16'd1, 16'd0, 16'd4, 16'hFFFF, 16'd9, 16'd2};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   logic        calm = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          sent_cnt = 0;
   int          cur_delay = int'(ACK_DELAY_RESET);

   int          mismatches;
   int          waiting;
   int          irq_pulses;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   game_pad_serial_port_unit dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_wdata
   );

   gpsp_port_checker port_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_wdata,
      .mismatches, .waiting, .irq_pulses
   );

   // response side: random stalls, one long hold-off, none while calm
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= 60;
         hold_done <= 1'b1;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 14);
      end
   end

   function automatic req_type mk(input logic [2:0] f, input logic [4:0] off,
                                  input logic [15:0] wd, input logic [15:0] bt);
      req_type r;
      r.func = f;
      r.reg_offset = off;
      r.wdata = wd;
      r.pad_buttons = bt;
      return r;
   endfunction

   // offer one request and hold it until taken, then maybe idle
   task automatic send_req(input req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_cnt++;
      if (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic access(input logic [2:0] f, input logic [4:0] off, input logic [15:0] wd);
      send_req(mk(f, off, wd, 16'($urandom)));
   endtask

   task automatic ticks(input int n);
      repeat (n) send_req(mk(FUNC_TICK, 5'($urandom), 16'($urandom), 16'($urandom)));
   endtask

   // stop offering and wait until every response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   task automatic write_delay(input logic [15:0] d);
      csr_valid <= 1'b1;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_delay = int'(d);
   endtask

   // ticks after a transmit: for delays up to 16 usually enough to fire, sometimes short; longer delays always short
   function automatic int settle_ticks();
      if (cur_delay > 16) return $urandom_range(12);
      if ($urandom_range(99) < 15) return $urandom_range(cur_delay);
      return cur_delay + $urandom_range(2);
   endfunction

   // select the pad, then mostly start, read command and two button bytes
   task automatic pad_exchange();
      logic [15:0] cw;
      logic [7:0]  tx;
      cw = 16'($urandom);
      cw[1] = 1'b1;
      cw[13] = 1'b0;
      cw[CTRL_RESET_BIT] = 1'b0;
      access(FUNC_WR_HALF, OFF_CTRL, cw);
      for (int k = 0; k < 4; k++) begin
         tx = 8'($urandom);
         if (k == 0 && $urandom_range(9) != 0) tx = TX_START;
         if (k == 1 && $urandom_range(6) != 0) tx = CMD_READ;
         access(FUNC_WR_BYTE, OFF_FIFO, {8'($urandom), tx});
         if ($urandom_range(3) == 0) access(FUNC_RD_HALF, OFF_STAT, 16'($urandom));
         ticks(settle_ticks());
         if ($urandom_range(2) == 0) access(FUNC_RD_BYTE, OFF_FIFO, 16'($urandom));
      end
      repeat ($urandom_range(6)) access(FUNC_RD_BYTE, OFF_FIFO, 16'($urandom));
      if ($urandom_range(1) == 0) access(FUNC_RD_HALF, OFF_STAT, 16'($urandom));
   endtask

   // time-outs, port resets, interrupt clears and fifo overfill
   task automatic broken_sequence();
      case ($urandom_range(3))
         0: access(FUNC_WR_HALF, OFF_CTRL, 16'h0000);
         1: access(FUNC_WR_HALF, OFF_CTRL, 16'($urandom) | (16'd1 << CTRL_RESET_BIT));
         2: access(FUNC_WR_HALF, OFF_CTRL,
                   (16'd1 << CTRL_ACK_IRQ_BIT) | (16'd1 << CTRL_RX_IRQ_BIT) | CTRL_PAD_SEL);
         default: begin
            access(FUNC_WR_HALF, OFF_CTRL,
                   16'($urandom) & ~CTRL_PAD_SEL & ~(16'd1 << CTRL_RESET_BIT));
            repeat ($urandom_range(1, 10)) access(FUNC_WR_BYTE, OFF_FIFO, 16'($urandom));
            access(FUNC_RD_HALF, OFF_STAT, 16'($urandom));
         end
      endcase
   endtask

   // any access, biased toward the mapped registers
   task automatic noise_access();
      logic [4:0] off;
      off = 5'($urandom);
      case ($urandom_range(5))
         0: off = OFF_FIFO;
         1: off = OFF_STAT;
         2: off = OFF_CTRL;
         3: off = OFF_BAUD;
         4: off = OFF_MODE;
         default: ;
      endcase
      send_req(mk(3'($urandom), off, 16'($urandom), 16'($urandom)));
   endtask

   initial begin
      int  start;
      int  pick;
      bit  paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register map, empty fifo, bad accesses and the upper window
      send_req(mk(FUNC_RD_HALF, OFF_BAUD, 16'hFFFF, 16'h0000));
      send_req(mk(FUNC_RD_HALF, OFF_CTRL, 16'h0000, 16'hFFFF));
      access(FUNC_RD_HALF, OFF_STAT, '0);
      access(FUNC_RD_BYTE, OFF_FIFO, '0);
      access(FUNC_RD_BYTE, OFF_STAT, '0);
      for (int f = int'(FUNC_TICK) + 1; f < 8; f++) access(3'(f), OFF_FIFO, 16'hFFFF);
      access(FUNC_RD_HALF, 5'd31, '0);
      access(FUNC_WR_HALF, 5'd16, 16'hFFFF);
      access(FUNC_WR_HALF, OFF_MODE, 16'hFFFF);
      access(FUNC_WR_HALF, OFF_BAUD, 16'h0000);
      access(FUNC_WR_HALF, OFF_STAT, 16'hFFFF);
      access(FUNC_WR_BYTE, 5'd15, 16'h0001);
      access(FUNC_RD_HALF, 5'd2, '0);
      // transmit with the pad deselected pushes a filler byte
      access(FUNC_WR_BYTE, OFF_FIFO, {8'h00, TX_START});
      access(FUNC_RD_HALF, OFF_STAT, '0);
      access(FUNC_RD_BYTE, OFF_FIFO, '0);
      access(FUNC_WR_HALF, OFF_CTRL, 16'hFFFF);
      access(FUNC_RD_HALF, OFF_CTRL, '0);
      access(FUNC_WR_HALF, OFF_CTRL, 16'h0000);

      // acknowledge at the reset delay, checked one tick before and at the firing tick
      access(FUNC_WR_HALF, OFF_CTRL, (16'd1 << CTRL_RX_IRQ_BIT) | CTRL_PAD_SEL);
      access(FUNC_WR_BYTE, OFF_FIFO, {8'h00, TX_START});
      ticks(int'(ACK_DELAY_RESET) - 1);
      access(FUNC_RD_HALF, OFF_STAT, '0);
      ticks(1);
      access(FUNC_RD_HALF, OFF_STAT, '0);
      access(FUNC_RD_BYTE, OFF_FIFO, '0);
      access(FUNC_WR_HALF, OFF_CTRL, (16'd1 << CTRL_ACK_IRQ_BIT) | CTRL_PAD_SEL);

      // random traffic under each acknowledge delay
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_delay(DELAYS[ph]);
         calm <= (ph == 2);
         start = sent_cnt;
         while (sent_cnt - start < 25 || (ph == 5 && !paused)) begin
            if (ph == 4 && !hold_go) hold_go <= 1'b1;
            if (ph == 5 && !paused && sent_cnt != start) begin
               wait_drained();
               paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55) pad_exchange();
            else if (pick < 75) broken_sequence();
            else repeat ($urandom_range(1, 6)) noise_access();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      $display("%0d requests checked across %0d acknowledge delay settings", sent_cnt, 7);
      $display("%0d receive interrupts raised by acknowledges", irq_pulses);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
rtl/gpsp_pkg.sv
rtl/gpsp_fifo.sv
rtl/gpsp_core.sv
rtl/game_pad_serial_port_unit.sv
tb/gpsp_port_checker.sv
tb/game_pad_serial_port_unit_tb.sv
